/* hw/rtl/apc_pkg.sv */
// Shared widths, register indexes and codes for the box pair contact block.
`default_nettype none
package apc_pkg;

	localparam int COORD_WIDTH_DEF = 22;
	localparam int DEPTH_WIDTH     = 25;
	localparam int CONTACT_WIDTH   = 26;
	localparam int REG_IDX_WIDTH   = 3;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_OWN_LOW_X  = 3'd0,
		REG_OWN_LOW_Y  = 3'd1,
		REG_OWN_LOW_Z  = 3'd2,
		REG_OWN_HIGH_X = 3'd3,
		REG_OWN_HIGH_Y = 3'd4,
		REG_OWN_HIGH_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

endpackage
`default_nettype wire

/* hw/rtl/apc_in_if.sv */
// Input channel: translations of both bodies and the other box bounds.
`default_nettype none
interface apc_in_if
	import apc_pkg::*;
	#(parameter int COORD_WIDTH = COORD_WIDTH_DEF);

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] own_shift_x;
	logic signed [COORD_WIDTH-1:0] own_shift_y;
	logic signed [COORD_WIDTH-1:0] own_shift_z;
	logic signed [COORD_WIDTH-1:0] peer_shift_x;
	logic signed [COORD_WIDTH-1:0] peer_shift_y;
	logic signed [COORD_WIDTH-1:0] peer_shift_z;
	logic signed [COORD_WIDTH-1:0] peer_low_x;
	logic signed [COORD_WIDTH-1:0] peer_low_y;
	logic signed [COORD_WIDTH-1:0] peer_low_z;
	logic signed [COORD_WIDTH-1:0] peer_high_x;
	logic signed [COORD_WIDTH-1:0] peer_high_y;
	logic signed [COORD_WIDTH-1:0] peer_high_z;

	modport source (
		output valid, own_shift_x, own_shift_y, own_shift_z,
		       peer_shift_x, peer_shift_y, peer_shift_z,
		       peer_low_x, peer_low_y, peer_low_z,
		       peer_high_x, peer_high_y, peer_high_z,
		input  ready
	);

	modport sink (
		input  valid, own_shift_x, own_shift_y, own_shift_z,
		       peer_shift_x, peer_shift_y, peer_shift_z,
		       peer_low_x, peer_low_y, peer_low_z,
		       peer_high_x, peer_high_y, peer_high_z,
		output ready
	);

endinterface
`default_nettype wire

/* hw/rtl/apc_out_if.sv */
// Output channel: hit flag, contact normal, depth and contact point.
`default_nettype none
interface apc_out_if
	import apc_pkg::*;
	();

	logic                            valid;
	logic                            ready;
	logic                            hit;
	logic [1:0]                      normal_axis;
	logic                            normal_negative;
	logic [DEPTH_WIDTH-1:0]          depth;
	logic signed [CONTACT_WIDTH-1:0] contact_x;
	logic signed [CONTACT_WIDTH-1:0] contact_y;
	logic signed [CONTACT_WIDTH-1:0] contact_z;

	modport source (
		output valid, hit, normal_axis, normal_negative, depth,
		       contact_x, contact_y, contact_z,
		input  ready
	);

	modport sink (
		input  valid, hit, normal_axis, normal_negative, depth,
		       contact_x, contact_y, contact_z,
		output ready
	);

endinterface
`default_nettype wire

/* hw/rtl/aabb_pair_contact.sv */
// An accepted pair moves from the input register into the result register.
// Throughput: one box pair per cycle unless the output stalls; the input and result
//   registers each hold one transaction and advance whenever the next stage frees.
// Every result costs one pass of add, compare and select logic between the two.
// Reset clears the valid flags of both stages and the own box bounds to zero.
`default_nettype none
module aabb_pair_contact
	import apc_pkg::*;
	#(parameter int COORD_WIDTH = COORD_WIDTH_DEF)
	(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [REG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [COORD_WIDTH-1:0]   cfg_data,
	apc_in_if.sink                        pair,
	apc_out_if.source                     contact
	);

	// Doubled centres, extents, differences and overlaps grow by up to four bits.
	localparam int IW = COORD_WIDTH + 6;
	localparam int EW = (IW > CONTACT_WIDTH) ? IW : CONTACT_WIDTH;

	logic signed [COORD_WIDTH-1:0] own_low_q  [3];
	logic signed [COORD_WIDTH-1:0] own_high_q [3];

	logic signed [COORD_WIDTH-1:0] own_shift [3];
	logic signed [COORD_WIDTH-1:0] peer_shift[3];
	logic signed [COORD_WIDTH-1:0] peer_low  [3];
	logic signed [COORD_WIDTH-1:0] peer_high [3];

	logic signed [EW-1:0] c1_s1[3], e1_s1[3], c2_s1[3], e2_s1[3];
	logic                 valid_s1;
	logic                 ready_s1;

	logic signed [EW-1:0] d  [3];
	logic signed [EW-1:0] ad [3];
	logic signed [EW-1:0] ov [3];
	logic signed [EW-1:0] pt [3];
	logic                 hit_c;
	axis_t                axis_c;
	logic signed [EW-1:0] d_sel, ov_sel;

	logic                            valid_s2;
	logic                            ready_s2;
	logic                            hit_s2;
	axis_t                           axis_s2;
	logic                            neg_s2;
	logic [DEPTH_WIDTH-1:0]          depth_s2;
	logic signed [CONTACT_WIDTH-1:0] pt_s2[3];

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				own_low_q[a]  <= '0;
				own_high_q[a] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_OWN_LOW_X:  own_low_q[0]  <= cfg_data;
				REG_OWN_LOW_Y:  own_low_q[1]  <= cfg_data;
				REG_OWN_LOW_Z:  own_low_q[2]  <= cfg_data;
				REG_OWN_HIGH_X: own_high_q[0] <= cfg_data;
				REG_OWN_HIGH_Y: own_high_q[1] <= cfg_data;
				REG_OWN_HIGH_Z: own_high_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign own_shift[0]  = pair.own_shift_x;
	assign own_shift[1]  = pair.own_shift_y;
	assign own_shift[2]  = pair.own_shift_z;
	assign peer_shift[0] = pair.peer_shift_x;
	assign peer_shift[1] = pair.peer_shift_y;
	assign peer_shift[2] = pair.peer_shift_z;
	assign peer_low[0]   = pair.peer_low_x;
	assign peer_low[1]   = pair.peer_low_y;
	assign peer_low[2]   = pair.peer_low_z;
	assign peer_high[0]  = pair.peer_high_x;
	assign peer_high[1]  = pair.peer_high_y;
	assign peer_high[2]  = pair.peer_high_z;

	assign ready_s2   = !valid_s2 || contact.ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign pair.ready = ready_s1;

	// Input stage: doubled centres and extents of both boxes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid && ready_s1) begin
			for (int a = 0; a < 3; a++) begin
				c1_s1[a] <= EW'(own_high_q[a]) + EW'(own_low_q[a])
				            + (EW'(own_shift[a]) <<< 1);
				e1_s1[a] <= EW'(own_high_q[a]) - EW'(own_low_q[a]);
				c2_s1[a] <= EW'(peer_high[a]) + EW'(peer_low[a])
				            + (EW'(peer_shift[a]) <<< 1);
				e2_s1[a] <= EW'(peer_high[a]) - EW'(peer_low[a]);
			end
		end
	end

	// Overlap per axis, least-overlap axis and contact point.
	always_comb begin
		hit_c = 1'b1;
		for (int a = 0; a < 3; a++) begin
			d[a]  = c2_s1[a] - c1_s1[a];
			ad[a] = d[a][EW-1] ? -d[a] : d[a];
			ov[a] = e1_s1[a] + e2_s1[a] - ad[a];
			if (ov[a] <= 0) hit_c = 1'b0;
			if (d[a] > 0)
				pt[a] = c1_s1[a] + e1_s1[a] - ov[a];
			else if (d[a] < 0)
				pt[a] = c1_s1[a] - e1_s1[a] + ov[a];
			else
				pt[a] = c1_s1[a];
		end
		// x only when strictly least; z wins a tie with y
		if (ov[0] < ov[1] && ov[0] < ov[2])
			axis_c = AXIS_X;
		else if (ov[1] < ov[2])
			axis_c = AXIS_Y;
		else
			axis_c = AXIS_Z;
		case (axis_c)
			AXIS_X:  begin d_sel = d[0]; ov_sel = ov[0]; end
			AXIS_Y:  begin d_sel = d[1]; ov_sel = ov[1]; end
			default: begin d_sel = d[2]; ov_sel = ov[2]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			hit_s2 <= hit_c;
			if (hit_c) begin
				axis_s2  <= axis_c;
				neg_s2   <= !(d_sel > 0);
				depth_s2 <= ov_sel[DEPTH_WIDTH-1:0];
				for (int a = 0; a < 3; a++)
					pt_s2[a] <= pt[a][CONTACT_WIDTH-1:0];
			end else begin
				axis_s2  <= AXIS_X;
				neg_s2   <= 1'b0;
				depth_s2 <= '0;
				for (int a = 0; a < 3; a++)
					pt_s2[a] <= '0;
			end
		end
	end

	assign contact.valid           = valid_s2;
	assign contact.hit             = hit_s2;
	assign contact.normal_axis     = axis_s2;
	assign contact.normal_negative = neg_s2;
	assign contact.depth           = depth_s2;
	assign contact.contact_x       = pt_s2[0];
	assign contact.contact_y       = pt_s2[1];
	assign contact.contact_z       = pt_s2[2];

endmodule
`default_nettype wire
